FILE: rtl/core/bfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfl_pkg
// types and constants shared by the fifo with drop range log
// ----------------------------------------------------------------------------
package bfl_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int RANGE_SLOTS  = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int RIDX_W       = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int RCNT_W       = $clog2(RANGE_SLOTS + 1);

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_REFUSED  = 3'd2;
    localparam logic [2:0] ST_POPPED   = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_LOST     = 3'd5;
    localparam logic [2:0] ST_NOT_LOST = 3'd6;

    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_ACCEPTING = 1'b1;

    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] sequence_req;
        logic [63:0] payload;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] data_out;
        logic [63:0] seq_out;
        logic [6:0]  fill_level;
        logic [6:0]  peak_fill;
        logic [63:0] drops_total;
        logic [4:0]  ranges_used;
        logic        log_overflowed;
        logic [63:0] first_unsure_seq;
        logic [63:0] max_accepted_seq;
    } out_word_t;

    // control to the range cell chain
    typedef struct packed {
        logic        start;
        logic        append;
        logic        extend;
        logic [63:0] seq;
        logic [RCNT_W-1:0] count;
    } chain_ctl_t;

endpackage

FILE: rtl/core/bfl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfl_ram
// generic single port write, single port registered read memory
// ----------------------------------------------------------------------------
module bfl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bfl_range_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfl_range_cell
// one stored loss range; passes the query and hit flag down the chain
// ----------------------------------------------------------------------------
module bfl_range_cell
    import bfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RIDX_W-1:0] my_idx,
    input  bfl_pkg::chain_ctl_t ctl,
    input  logic              hit_in,
    input  logic              act_in,
    input  logic [63:0]       q_in,
    output logic              hit_out,
    output logic              act_out,
    output logic [63:0]       q_out,
    output logic [63:0]       last_seq
);

    logic [63:0] first_reg;
    logic [63:0] last_reg;
    logic        here;
    logic        valid_idx;

    assign valid_idx = {1'b0, my_idx} < ctl.count;
    assign here = act_in && valid_idx && (q_in >= first_reg) && (q_in <= last_reg);

    // range storage
    always_ff @(posedge clk)
    begin
        if (ctl.append && ({1'b0, my_idx} == ctl.count))
        begin
            first_reg <= ctl.seq;
            last_reg  <= ctl.seq;
        end
        else if (ctl.extend && ({1'b0, my_idx} == ctl.count - 1'b1))
        begin
            last_reg <= ctl.seq;
        end
    end

    // query token moves one cell a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_out <= 1'b0;
            hit_out <= 1'b0;
        end
        else
        begin
            act_out <= act_in;
            hit_out <= hit_in | here;
        end
    end

    always_ff @(posedge clk)
    begin
        q_out <= q_in;
    end

    assign last_seq = last_reg;

endmodule

FILE: rtl/core/bfl_range_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfl_range_chain
// row of range cells; a query walks one cell per cycle
// ----------------------------------------------------------------------------
module bfl_range_chain
    import bfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  bfl_pkg::chain_ctl_t ctl,
    output logic                done,
    output logic                hit,
    output logic [63:0]         tail_last
);

    logic        hit_w [RANGE_SLOTS+1];
    logic        act_w [RANGE_SLOTS+1];
    logic [63:0] q_w   [RANGE_SLOTS+1];
    logic [63:0] last_w [RANGE_SLOTS];
    logic [RIDX_W-1:0] tidx;

    assign hit_w[0] = 1'b0;
    assign act_w[0] = ctl.start;
    assign q_w[0]   = ctl.seq;

    genvar g;
    generate
        for (g = 0; g < RANGE_SLOTS; g++)
        begin : g_cell
            bfl_range_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .my_idx  (RIDX_W'(g)),
                .ctl     (ctl),
                .hit_in  (hit_w[g]),
                .act_in  (act_w[g]),
                .q_in    (q_w[g]),
                .hit_out (hit_w[g+1]),
                .act_out (act_w[g+1]),
                .q_out   (q_w[g+1]),
                .last_seq(last_w[g])
            );
        end
    endgenerate

    // last stored range end for folding
    assign tidx      = RIDX_W'(ctl.count - 1'b1);
    assign tail_last = last_w[tidx];
    assign done      = act_w[RANGE_SLOTS];
    assign hit       = hit_w[RANGE_SLOTS];

endmodule

FILE: rtl/core/bounded_fifo_with_loss_range_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_fifo_with_loss_range_log
// ring fifo with drop counter and a log of dropped sequence ranges
// ----------------------------------------------------------------------------
// One word is handled at a time. A push (accepted, refused or dropped) and a pop
// of an empty fifo go from the accept cycle straight to the output state; a pop
// that finds an item passes through S_POP first, as it waits for the registered
// slot RAM read; a query stays in S_QUERY as it walks the row of range cells
// one cell per cycle. The result sits in an output register, and the next
// word is accepted on the cycle after that register has been taken.
module bounded_fifo_with_loss_range_log
    import bfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bfl_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bfl_pkg::out_word_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_QUERY = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [6:0]       cap_reg;
    logic             acc_reg;
    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [OCC_W-1:0] occ_reg, high_reg;
    logic [63:0]      drops_reg, unsure_reg, top_reg;
    logic [RCNT_W-1:0] rcnt_reg;
    logic             unk_reg;
    out_word_t        out_reg;
    logic             take;
    logic [OCC_W-1:0] used_cap;
    logic [PTR_W-1:0] head_adv, tail_adv;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [63:0]      rd_seq;
    logic             do_push, do_drop, fold, append;
    chain_ctl_t       ctl;
    logic             q_done, q_hit;
    logic [63:0]      tail_last;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid;
    assign cfg_ready = 1'b1;
    assign take      = in_valid && in_ready;
    assign out_data  = out_reg;

    // effective capacity
    always_comb
    begin
        if (cap_reg == 7'd0)
            used_cap = OCC_W'(1);
        else if (cap_reg > 7'(QUEUE_DEPTH))
            used_cap = OCC_W'(QUEUE_DEPTH);
        else
            used_cap = OCC_W'(cap_reg);
    end

    assign head_adv = ({1'b0, head_reg} + 1'b1 >= (PTR_W+1)'(used_cap)) ? '0 : head_reg + 1'b1;
    assign tail_adv = ({1'b0, tail_reg} + 1'b1 >= (PTR_W+1)'(used_cap)) ? '0 : tail_reg + 1'b1;

    // push decision
    assign do_push = take && in_data.kind == KIND_PUSH && acc_reg && occ_reg < used_cap;
    assign do_drop = take && in_data.kind == KIND_PUSH && acc_reg && occ_reg >= used_cap;
    assign fold    = rcnt_reg != '0 && tail_last != ALL_ONES
                     && tail_last + 64'd1 == in_data.sequence_req;
    assign append  = do_drop && !unk_reg && !fold && rcnt_reg < RCNT_W'(RANGE_SLOTS);

    always_comb
    begin
        ctl.start  = take && in_data.kind != KIND_PUSH && in_data.kind != KIND_POP;
        ctl.append = append;
        ctl.extend = do_drop && !unk_reg && fold;
        ctl.seq    = in_data.sequence_req;
        ctl.count  = rcnt_reg;
    end

    bfl_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(QUEUE_DEPTH)) u_pay (
        .clk(clk), .we(do_push), .waddr(tail_reg),
        .wdata(in_data.payload[PAYLOAD_BITS-1:0]), .raddr(head_reg), .rdata(rd_pay)
    );

    bfl_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_seq (
        .clk(clk), .we(do_push), .waddr(tail_reg),
        .wdata(in_data.sequence_req), .raddr(head_reg), .rdata(rd_seq)
    );

    bfl_range_chain u_chain (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .done(q_done), .hit(q_hit), .tail_last(tail_last)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (in_data.kind == KIND_PUSH)
                        state_next = S_OUT;
                    else if (in_data.kind == KIND_POP)
                        state_next = (occ_reg == '0) ? S_OUT : S_POP;
                    else
                        state_next = S_QUERY;
                end
            end
            S_POP:   state_next = S_OUT;
            S_QUERY: state_next = q_done ? S_OUT : S_QUERY;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg   <= 7'd64;
            acc_reg   <= 1'b1;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            high_reg  <= '0;
            drops_reg <= '0;
            unsure_reg <= '0;
            top_reg   <= '0;
            rcnt_reg  <= '0;
            unk_reg   <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_CAPACITY)
                    cap_reg <= cfg_data;
                else
                    acc_reg <= cfg_data[0];
            end
            if (do_push)
            begin
                tail_reg <= tail_adv;
                occ_reg  <= occ_reg + 1'b1;
                if (occ_reg + 1'b1 > high_reg)
                    high_reg <= occ_reg + 1'b1;
                if (in_data.sequence_req > top_reg)
                    top_reg <= in_data.sequence_req;
            end
            if (do_drop)
            begin
                drops_reg <= drops_reg + 64'd1;
                if (append)
                    rcnt_reg <= rcnt_reg + 1'b1;
                else if (!unk_reg && !fold)
                begin
                    unk_reg    <= 1'b1;
                    unsure_reg <= in_data.sequence_req;
                end
            end
            if (take && in_data.kind == KIND_POP && occ_reg != '0)
            begin
                head_reg <= head_adv;
                occ_reg  <= occ_reg - 1'b1;
            end
            if (state_reg == S_OUT)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.data_out <= '0;
            out_reg.seq_out  <= '0;
            if (in_data.kind == KIND_PUSH)
                out_reg.status <= !acc_reg ? ST_REFUSED : (do_drop ? ST_DROPPED : ST_ACCEPTED);
            else if (in_data.kind == KIND_POP)
                out_reg.status <= (occ_reg == '0) ? ST_EMPTY : ST_POPPED;
            else
                out_reg.status <= ST_NOT_LOST;
        end
        if (state_reg == S_POP)
        begin
            out_reg.data_out <= 64'(rd_pay);
            out_reg.seq_out  <= rd_seq;
        end
        if (state_reg == S_QUERY && q_done)
            out_reg.status <= q_hit ? ST_LOST : ST_NOT_LOST;
        if (state_reg == S_OUT)
        begin
            out_reg.fill_level       <= 7'(occ_reg);
            out_reg.peak_fill        <= 7'(high_reg);
            out_reg.drops_total      <= drops_reg;
            out_reg.ranges_used      <= 5'(rcnt_reg);
            out_reg.log_overflowed   <= unk_reg;
            out_reg.first_unsure_seq <= unsure_reg;
            out_reg.max_accepted_seq <= top_reg;
        end
    end

endmodule
